[hw/rtl/pfa_pkg.sv]
// Shared constants, types and helpers of the page frame allocator.
package pfa_pkg;

  localparam int unsigned MAX_PAGES  = 4096;
  localparam int unsigned PAGE_SHIFT = 12;

  localparam int unsigned PG_AW   = $clog2(MAX_PAGES);
  localparam int unsigned LINK_W  = PG_AW + 1;
  localparam int unsigned ADDR_W  = 52;
  localparam int unsigned BASE_W  = 40;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned USE_W   = 4;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned REGN_W  = 3;
  localparam int unsigned CFG_AW  = 4;
  localparam int unsigned CFG_DW  = 64;
  localparam int unsigned NUM_USE = 1 << USE_W;

  localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(MAX_PAGES);
  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0]  PCOUNT_RST = CNT_W'(4096);

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALLOC_ZERO = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC_FREE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REL_ZERO   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REL_FREE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MARK_ACT   = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOPAGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE  = 2'd2;

  // Region codes
  localparam logic [REGN_W-1:0] RGN_BAD    = 3'd0;
  localparam logic [REGN_W-1:0] RGN_FREE   = 3'd1;
  localparam logic [REGN_W-1:0] RGN_ZERO   = 3'd2;
  localparam logic [REGN_W-1:0] RGN_ACTIVE = 3'd4;

  // Register map index
  localparam logic CFG_BASE_PAGE  = 1'b0;
  localparam logic CFG_PAGE_COUNT = 1'b1;

  typedef struct packed {
    logic              referenced;
    logic [REGN_W-1:0] region;
    logic [USE_W-1:0]  use_class;
  } pt_entry_t;

  localparam int unsigned PT_W = $bits(pt_entry_t);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] c);
    sat_dec = (c == '0) ? c : c - CNT_W'(1);
  endfunction

endpackage

[hw/rtl/pfa_req_if.sv]
// Command channel of the page frame allocator.
interface pfa_req_if import pfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] page_address;
  logic [USE_W-1:0]  page_use;

  modport source (output valid, cmd, page_address, page_use, input ready);
  modport sink   (input valid, cmd, page_address, page_use, output ready);
endinterface

[hw/rtl/pfa_rsp_if.sv]
// Result channel of the page frame allocator.
interface pfa_rsp_if import pfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] granted_address;
  logic [CNT_W-1:0]  free_count;
  logic [CNT_W-1:0]  zero_count;
  logic [CNT_W-1:0]  active_count;
  logic [CNT_W-1:0]  use_count;

  modport source (output valid, status, granted_address, free_count, zero_count,
                  active_count, use_count, input ready);
  modport sink   (input valid, status, granted_address, free_count, zero_count,
                  active_count, use_count, output ready);
endinterface

[hw/rtl/pfa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module pfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hw/rtl/page_frame_allocator_unit.sv]
// Page frame allocator: per-page table plus LIFO zeroed and free lists in RAM.
//
// The block tracks up to MAX_PAGES physical pages. For each page a RAM holds
// its use class, its region (bad, free, zeroed, active) and a reference flag;
// two more RAMs hold the next and previous links of the doubly linked zeroed
// and free lists. One command is processed at a time: a transaction on req_i
// starts it and exactly one transaction on rsp_o reports it. A command that
// fails or touches nothing (out of range, empty lists, unknown code) goes
// straight to its result; the release of a page that is already listed
// only reads its page entry first; allocate, mark active and release also
// update links and use counters. Every result then waits for rsp_o.ready.
// The steps follow the chain of dependent reads and writes of the page and
// link RAMs (registered reads) and the use counters, which are updated one
// per cycle. After reset the block sweeps the page RAM once to mark every
// page bad; req_i.ready is low during the sweep, and the APB port is
// served meanwhile. The APB registers are base_page at 0x0 and page_count at
// 0x8 (64-bit data); write them only while no command is in flight.
module page_frame_allocator_unit import pfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  pfa_req_if.sink           req_i,
  pfa_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ALINK, S_PT, S_REL2, S_REL3, S_TAKE, S_TAKE2, S_FIN, S_OUT
  } state_e;

  state_e            state_q;
  logic [PG_AW-1:0]  clr_q;

  // Configuration
  logic [BASE_W-1:0] base_q;
  logic [CNT_W-1:0]  pcount_q;

  // Command context
  logic [CMD_W-1:0]  cmd_q;
  logic [USE_W-1:0]  use_q;
  logic [PG_AW-1:0]  idx_q;
  logic              sel_zero_q;
  pt_entry_t         old_q;
  logic [LINK_W-1:0] ohead_q;

  // List heads and counters
  logic [LINK_W-1:0] free_head_q, zero_head_q;
  logic [CNT_W-1:0]  cnt_free_q, cnt_zero_q, cnt_act_q;
  logic [CNT_W-1:0]  use_cnt_q [NUM_USE];

  // Result
  logic [STAT_W-1:0] status_q;
  logic [ADDR_W-1:0] granted_q;
  logic [CNT_W-1:0]  out_use_q;

  // RAM ports
  logic              pt_we, nx_we, pv_we;
  logic [PG_AW-1:0]  pt_waddr, nx_waddr, pv_waddr, raddr;
  pt_entry_t         pt_wdata, pt_rdata;
  logic [PT_W-1:0]   pt_rraw;
  logic [LINK_W-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;

  //--------------------------------------------------------------------------
  // APB configuration port
  //--------------------------------------------------------------------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3])
      CFG_BASE_PAGE:  prdata = CFG_DW'(base_q);
      CFG_PAGE_COUNT: prdata = CFG_DW'(pcount_q);
      default:        prdata = '0;
    endcase
  end

  //--------------------------------------------------------------------------
  // Address check and list choice for the incoming command
  //--------------------------------------------------------------------------
  logic [BASE_W-1:0] pfn, lim;
  logic [BASE_W:0]   diff;
  logic              in_rng;
  logic [PG_AW-1:0]  in_idx;
  logic              is_alloc, z_ok, f_ok, use_zero;
  logic [LINK_W-1:0] pick, head_t;

  assign pfn    = BASE_W'(req_i.page_address >> PAGE_SHIFT);
  assign lim    = (BASE_W'(pcount_q) > BASE_W'(MAX_PAGES)) ? BASE_W'(MAX_PAGES)
                                                            : BASE_W'(pcount_q);
  assign diff   = {1'b0, pfn} - {1'b0, base_q};
  assign in_rng = !diff[BASE_W] && (diff[BASE_W-1:0] < lim);
  assign in_idx = diff[PG_AW-1:0];

  assign is_alloc = (req_i.cmd == CMD_ALLOC_ZERO) || (req_i.cmd == CMD_ALLOC_FREE);
  assign z_ok     = zero_head_q != NIL_LINK;
  assign f_ok     = free_head_q != NIL_LINK;
  // Zero-first takes the zeroed list when it has a page; free-first falls
  // back to it only when the free list is empty.
  assign use_zero = (req_i.cmd == CMD_ALLOC_ZERO) ? z_ok : !f_ok;
  assign pick     = use_zero ? zero_head_q : free_head_q;
  assign head_t   = sel_zero_q ? zero_head_q : free_head_q;

  // Decode of the page entry just read
  logic listed;
  assign pt_rdata = pt_entry_t'(pt_rraw);
  assign listed   = (pt_rdata.region == RGN_FREE) || (pt_rdata.region == RGN_ZERO);

  // Use counter port: one counter read and updated per cycle
  logic [USE_W-1:0] uc_idx;
  logic [CNT_W-1:0] uc_val;
  always_comb begin
    case (state_q)
      S_REL2, S_TAKE: uc_idx = old_q.use_class;
      S_REL3:         uc_idx = '0;
      default:        uc_idx = use_q;
    endcase
  end
  assign uc_val = use_cnt_q[uc_idx];

  //--------------------------------------------------------------------------
  // RAM access control
  //--------------------------------------------------------------------------
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = idx_q;
    pt_wdata = '0;
    nx_we    = 1'b0;
    nx_waddr = idx_q;
    nx_wdata = NIL_LINK;
    pv_we    = 1'b0;
    pv_waddr = idx_q;
    pv_wdata = NIL_LINK;
    raddr    = is_alloc ? pick[PG_AW-1:0] : in_idx;

    unique case (state_q)
      S_CLEAR: begin
        // Mark every page bad, unused and unreferenced
        pt_we           = 1'b1;
        pt_waddr        = clr_q;
        pt_wdata.region = RGN_BAD;
      end
      S_ALINK: begin
        // Popped page was the head: its successor becomes head
        if (nx_rdata != NIL_LINK) begin
          pv_we    = 1'b1;
          pv_waddr = nx_rdata[PG_AW-1:0];
          pv_wdata = NIL_LINK;
        end
      end
      S_PT: begin
        if (cmd_q == CMD_MARK_ACT) begin
          if (listed) begin
            // Unlink from its place in its list
            if (pv_rdata != NIL_LINK) begin
              nx_we    = 1'b1;
              nx_waddr = pv_rdata[PG_AW-1:0];
              nx_wdata = nx_rdata;
            end
            if (nx_rdata != NIL_LINK) begin
              pv_we    = 1'b1;
              pv_waddr = nx_rdata[PG_AW-1:0];
              pv_wdata = pv_rdata;
            end
          end
        end else if (!listed) begin
          // Push on the head of the target list
          pt_we           = 1'b1;
          pt_wdata.region = sel_zero_q ? RGN_ZERO : RGN_FREE;
          nx_we           = 1'b1;
          nx_wdata        = head_t;
          pv_we           = 1'b1;
          pv_wdata        = NIL_LINK;
        end
      end
      S_REL2: begin
        if (ohead_q != NIL_LINK) begin
          pv_we    = 1'b1;
          pv_waddr = ohead_q[PG_AW-1:0];
          pv_wdata = {1'b0, idx_q};
        end
      end
      S_TAKE: begin
        pt_we               = 1'b1;
        pt_wdata.referenced = 1'b1;
        pt_wdata.region     = RGN_ACTIVE;
        pt_wdata.use_class  = use_q;
      end
      default: ;
    endcase
  end

  pfa_ram #(.WIDTH(PT_W), .DEPTH(MAX_PAGES)) u_page_ram (
    .clk_i, .we_i(pt_we), .waddr_i(pt_waddr), .wdata_i(pt_wdata),
    .raddr_i(raddr), .rdata_o(pt_rraw)
  );

  pfa_ram #(.WIDTH(LINK_W), .DEPTH(MAX_PAGES)) u_next_ram (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .raddr_i(raddr), .rdata_o(nx_rdata)
  );

  pfa_ram #(.WIDTH(LINK_W), .DEPTH(MAX_PAGES)) u_prev_ram (
    .clk_i, .we_i(pv_we), .waddr_i(pv_waddr), .wdata_i(pv_wdata),
    .raddr_i(raddr), .rdata_o(pv_rdata)
  );

  //--------------------------------------------------------------------------
  // Sequencer, heads, counters and result registers
  //--------------------------------------------------------------------------
  logic [BASE_W-1:0] gpfn;
  assign gpfn = BASE_W'(idx_q) + base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      base_q      <= '0;
      pcount_q    <= PCOUNT_RST;
      free_head_q <= NIL_LINK;
      zero_head_q <= NIL_LINK;
      cnt_free_q  <= '0;
      cnt_zero_q  <= '0;
      cnt_act_q   <= '0;
      for (int i = 0; i < NUM_USE; i++) begin
        use_cnt_q[i] <= (i == 0) ? PCOUNT_RST : '0;
      end
      cmd_q       <= '0;
      use_q       <= '0;
      idx_q       <= '0;
      sel_zero_q  <= 1'b0;
      old_q       <= '0;
      ohead_q     <= NIL_LINK;
      status_q    <= ST_DONE;
      granted_q   <= '0;
      out_use_q   <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3])
          CFG_BASE_PAGE:  base_q   <= pwdata[BASE_W-1:0];
          CFG_PAGE_COUNT: pcount_q <= pwdata[CNT_W-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + PG_AW'(1);
          if (clr_q == PG_AW'(MAX_PAGES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_i.valid) begin
            cmd_q     <= req_i.cmd;
            use_q     <= req_i.page_use;
            status_q  <= ST_DONE;
            granted_q <= '0;
            if (is_alloc) begin
              if (!(z_ok || f_ok)) begin
                status_q <= ST_NOPAGE;
                state_q  <= S_FIN;
              end else begin
                idx_q      <= pick[PG_AW-1:0];
                sel_zero_q <= use_zero;
                state_q    <= S_ALINK;
              end
            end else if ((req_i.cmd == CMD_REL_ZERO) || (req_i.cmd == CMD_REL_FREE) ||
                         (req_i.cmd == CMD_MARK_ACT)) begin
              if (!in_rng) begin
                status_q <= ST_RANGE;
                state_q  <= S_FIN;
              end else begin
                idx_q      <= in_idx;
                sel_zero_q <= req_i.cmd == CMD_REL_ZERO;
                state_q    <= S_PT;
              end
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_ALINK: begin
          old_q <= pt_rdata;
          if (sel_zero_q) begin
            zero_head_q <= nx_rdata;
            cnt_zero_q  <= sat_dec(cnt_zero_q);
          end else begin
            free_head_q <= nx_rdata;
            cnt_free_q  <= sat_dec(cnt_free_q);
          end
          state_q <= S_TAKE;
        end
        S_PT: begin
          old_q <= pt_rdata;
          if (cmd_q == CMD_MARK_ACT) begin
            if (listed) begin
              if (pt_rdata.region == RGN_ZERO) begin
                if (pv_rdata == NIL_LINK) zero_head_q <= nx_rdata;
                cnt_zero_q <= sat_dec(cnt_zero_q);
              end else begin
                if (pv_rdata == NIL_LINK) free_head_q <= nx_rdata;
                cnt_free_q <= sat_dec(cnt_free_q);
              end
            end
            state_q <= S_TAKE;
          end else if (listed) begin
            // Already on a list: leave it where it is
            state_q <= S_FIN;
          end else begin
            if (pt_rdata.region == RGN_ACTIVE) cnt_act_q <= sat_dec(cnt_act_q);
            ohead_q <= head_t;
            if (sel_zero_q) begin
              zero_head_q <= {1'b0, idx_q};
              cnt_zero_q  <= sat_inc(cnt_zero_q);
            end else begin
              free_head_q <= {1'b0, idx_q};
              cnt_free_q  <= sat_inc(cnt_free_q);
            end
            state_q <= S_REL2;
          end
        end
        S_REL2: begin
          use_cnt_q[uc_idx] <= sat_dec(uc_val);
          state_q           <= S_REL3;
        end
        S_REL3: begin
          use_cnt_q[uc_idx] <= sat_inc(uc_val);
          state_q           <= S_FIN;
        end
        S_TAKE: begin
          use_cnt_q[uc_idx] <= sat_dec(uc_val);
          if (old_q.region != RGN_ACTIVE) cnt_act_q <= sat_inc(cnt_act_q);
          state_q <= S_TAKE2;
        end
        S_TAKE2: begin
          use_cnt_q[uc_idx] <= sat_inc(uc_val);
          if ((cmd_q == CMD_ALLOC_ZERO) || (cmd_q == CMD_ALLOC_FREE)) begin
            granted_q <= ADDR_W'({gpfn, {PAGE_SHIFT{1'b0}}});
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          out_use_q <= uc_val;
          state_q   <= S_OUT;
        end
        S_OUT: begin
          if (rsp_o.ready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Channel outputs; counters hold still while a result waits
  //--------------------------------------------------------------------------
  assign req_i.ready           = state_q == S_IDLE;
  assign rsp_o.valid           = state_q == S_OUT;
  assign rsp_o.status          = status_q;
  assign rsp_o.granted_address = granted_q;
  assign rsp_o.free_count      = cnt_free_q;
  assign rsp_o.zero_count      = cnt_zero_q;
  assign rsp_o.active_count    = cnt_act_q;
  assign rsp_o.use_count       = out_use_q;

endmodule
